// File: design/plcrop_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the plate crop region calculator.
// No dependencies; used by plate_crop_region_calculator_top and its testbench.

package plcrop_pkg;

	// Field and port widths.
	localparam int IN_W        = 18;
	localparam int REG_W       = 14;
	localparam int OUT_W       = 14;
	localparam int CFG_ADDR_W  = 3;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 88;

	// Defaults for the top-level parameters.
	localparam int FRAC_BITS_DEF = 4;
	localparam int MAX_DIM_DEF   = 8192;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_BOX_WIDTH  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_BOX_HEIGHT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DEST_WIDTH     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_DEST_HEIGHT    = 3'd5;

	// Register reset values.
	localparam logic [REG_W-1:0] RST_FRAME_WIDTH    = 14'd1920;
	localparam logic [REG_W-1:0] RST_FRAME_HEIGHT   = 14'd1080;
	localparam logic [REG_W-1:0] RST_MIN_BOX_WIDTH  = 14'd16;
	localparam logic [REG_W-1:0] RST_MIN_BOX_HEIGHT = 14'd8;
	localparam logic [REG_W-1:0] RST_DEST_WIDTH     = 14'd160;
	localparam logic [REG_W-1:0] RST_DEST_HEIGHT    = 14'd48;

	// Reciprocals for the padding divisions. floor(v * R >> S) equals floor(v / d)
	// as long as v times the rounding excess stays below 2**S, which holds for
	// every value up to 65536.
	localparam int              RECIP_W       = 17;
	localparam logic [RECIP_W-1:0] RECIP12    = 17'd87382;
	localparam int              RECIP12_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP5     = 17'd52429;
	localparam int              RECIP5_SHIFT  = 18;

	// Smallest padding on each side.
	localparam int PAD_MIN = 2;

endpackage

// File: design/plate_crop_region_calculator_top.sv
`timescale 1ns / 1ps
// Top level of the plate crop region calculator: config registers, crop pipeline, output word.
// Depends on plcrop_pkg and plcrop_ceil_div.
//
//   channel   direction  handshake                       content
//   s_axis    in         s_axis_tvalid / s_axis_tready   one detection box per word
//   m_axis    out        m_axis_tvalid / m_axis_tready   one crop result per word
//   cfg       in         cfg_wr_en                       register write, no read-back
//
// A box passes six stages of rounding, alignment and padding, then one setup stage
// and one stage per quotient bit of the aspect divider, then the output register.
// One word is accepted every cycle while the output side takes words.
// The whole pipeline holds when a result waits in the output register; no word is lost.
// Reset clears the valid bits and loads the register defaults; no clearing pass is needed.

module plate_crop_region_calculator_top #(
	parameter int FRAC_BITS = plcrop_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIM   = plcrop_pkg::MAX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// box_left, box_top, box_right, box_bottom
	input  logic [plcrop_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// src_x, src_y, src_width, src_height, out_width, out_height, zero fill
	output logic [plcrop_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// accepted
	output logic                               m_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_wr_en,
	input  logic [plcrop_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [plcrop_pkg::REG_W-1:0]       cfg_wdata
);

	localparam int IN_W  = plcrop_pkg::IN_W;
	localparam int REG_W = plcrop_pkg::REG_W;
	localparam int OUT_W = plcrop_pkg::OUT_W;
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int QW    = DW + 1;
	localparam int SATW  = (REG_W > DW) ? REG_W : DW;
	localparam int RW    = IN_W - FRAC_BITS;
	localparam int CMPW  = (RW > DW) ? RW : DW;
	localparam int IW1   = IN_W + 1;
	localparam int PW    = DW + plcrop_pkg::RECIP_W;
	localparam int SIDE_W = 4 * DW + 1;
	localparam logic [IN_W:0] HALF = IW1'((1 << FRAC_BITS) >> 1);
	localparam logic [DW-1:0] PADMIN = DW'(plcrop_pkg::PAD_MIN);

	// ---------------------------------------------------------------- registers
	logic [REG_W-1:0] frame_width_q, frame_height_q, min_box_width_q, min_box_height_q;
	logic [REG_W-1:0] dest_width_q, dest_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= plcrop_pkg::RST_FRAME_WIDTH;
			frame_height_q   <= plcrop_pkg::RST_FRAME_HEIGHT;
			min_box_width_q  <= plcrop_pkg::RST_MIN_BOX_WIDTH;
			min_box_height_q <= plcrop_pkg::RST_MIN_BOX_HEIGHT;
			dest_width_q     <= plcrop_pkg::RST_DEST_WIDTH;
			dest_height_q    <= plcrop_pkg::RST_DEST_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				plcrop_pkg::REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata;
				plcrop_pkg::REG_FRAME_HEIGHT:   frame_height_q   <= cfg_wdata;
				plcrop_pkg::REG_MIN_BOX_WIDTH:  min_box_width_q  <= cfg_wdata;
				plcrop_pkg::REG_MIN_BOX_HEIGHT: min_box_height_q <= cfg_wdata;
				plcrop_pkg::REG_DEST_WIDTH:     dest_width_q     <= cfg_wdata;
				plcrop_pkg::REG_DEST_HEIGHT:    dest_height_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	function automatic logic [DW-1:0] sat_dim(input logic [REG_W-1:0] v);
		if (SATW'(v) > SATW'(MAX_DIM)) begin
			return DW'(MAX_DIM);
		end
		return DW'(v);
	endfunction

	// Round half up, then clamp into [0, dim-1]; a zero dimension gives 0.
	function automatic logic [DW-1:0] corner(input logic [IN_W-1:0] v,
			input logic [DW-1:0] dim);
		logic [IN_W:0] sum;
		logic [RW-1:0] r;
		sum = {v[IN_W-1], v} + HALF;
		r   = sum[IN_W-1:FRAC_BITS];
		if (sum[IN_W] || (dim == '0)) begin
			return '0;
		end
		if (CMPW'(r) >= CMPW'(dim)) begin
			return dim - DW'(1);
		end
		return DW'(r);
	endfunction

	// min(dim, even_floor(v + 1))
	function automatic logic [DW-1:0] align_up(input logic [DW-1:0] v,
			input logic [DW-1:0] dim);
		logic [DW:0] t;
		t = {1'b0, v} + (DW+1)'(1);
		t[0] = 1'b0;
		if (t > {1'b0, dim}) begin
			return dim;
		end
		return t[DW-1:0];
	endfunction

	// max(1, b - a)
	function automatic logic [DW-1:0] span(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] d;
		d = {1'b0, b} - {1'b0, a};
		if (d[DW] || (d == '0)) begin
			return DW'(1);
		end
		return d[DW-1:0];
	endfunction

	logic [DW-1:0] fw, fh, minw, minh, dw_sat, dh;

	assign fw     = sat_dim(frame_width_q);
	assign fh     = sat_dim(frame_height_q);
	assign minw   = sat_dim(min_box_width_q);
	assign minh   = sat_dim(min_box_height_q);
	assign dw_sat = sat_dim(dest_width_q);
	assign dh     = sat_dim(dest_height_q);

	// ---------------------------------------------------------------- flow control
	logic en;
	logic out_valid_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------------------------------------------------------- stage 1: corners
	logic [IN_W-1:0] in_left, in_top, in_right, in_bottom;
	logic [DW-1:0]   c_left, c_top, c_right, c_bottom;
	logic            v_s1;
	logic [DW-1:0]   x1_s1, y1_s1, x2_s1, y2_s1;

	assign in_left   = s_axis_tdata[0*IN_W +: IN_W];
	assign in_top    = s_axis_tdata[1*IN_W +: IN_W];
	assign in_right  = s_axis_tdata[2*IN_W +: IN_W];
	assign in_bottom = s_axis_tdata[3*IN_W +: IN_W];

	assign c_left   = corner(in_left, fw);
	assign c_top    = corner(in_top, fh);
	assign c_right  = corner(in_right, fw);
	assign c_bottom = corner(in_bottom, fh);

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= {c_left[DW-1:1], 1'b0};
			y1_s1 <= {c_top[DW-1:1], 1'b0};
			x2_s1 <= align_up(c_right, fw);
			y2_s1 <= align_up(c_bottom, fh);
		end
	end

	// ---------------------------------------------------------------- stage 2: box size
	logic          v_s2;
	logic [DW-1:0] x1_s2, y1_s2, x2_s2, y2_s2, w_s2, h_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2 <= x1_s1;
			y1_s2 <= y1_s1;
			x2_s2 <= x2_s1;
			y2_s2 <= y2_s1;
			w_s2  <= span(x1_s1, x2_s1);
			h_s2  <= span(y1_s1, y2_s1);
		end
	end

	// ---------------------------------------------------------------- stage 3: w/12, h/5
	logic          v_s3;
	logic [DW-1:0] x1_s3, y1_s3, x2_s3, y2_s3;
	logic [PW-1:0] pwp_s3, php_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
			x2_s3  <= x2_s2;
			y2_s3  <= y2_s2;
			pwp_s3 <= w_s2 * plcrop_pkg::RECIP12;
			php_s3 <= h_s2 * plcrop_pkg::RECIP5;
		end
	end

	// ---------------------------------------------------------------- stage 4: pad and align
	logic [DW-1:0] qx, qy, px, py;
	logic [DW-1:0] x1p, y1p, x2t, y2t;
	logic [DW:0]   x2sum, y2sum;
	logic          v_s4;
	logic [DW-1:0] x1_s4, y1_s4, x2_s4, y2_s4;

	assign qx = DW'(pwp_s3 >> plcrop_pkg::RECIP12_SHIFT);
	assign qy = DW'(php_s3 >> plcrop_pkg::RECIP5_SHIFT);
	assign px = (qx < PADMIN) ? PADMIN : qx;
	assign py = (qy < PADMIN) ? PADMIN : qy;

	assign x1p   = (x1_s3 > px) ? (x1_s3 - px) : '0;
	assign y1p   = (y1_s3 > py) ? (y1_s3 - py) : '0;
	assign x2sum = {1'b0, x2_s3} + {1'b0, px};
	assign y2sum = {1'b0, y2_s3} + {1'b0, py};
	assign x2t   = (x2sum > {1'b0, fw}) ? fw : x2sum[DW-1:0];
	assign y2t   = (y2sum > {1'b0, fh}) ? fh : y2sum[DW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s4 <= {x1p[DW-1:1], 1'b0};
			y1_s4 <= {y1p[DW-1:1], 1'b0};
			x2_s4 <= align_up(x2t, fw);
			y2_s4 <= align_up(y2t, fh);
		end
	end

	// ---------------------------------------------------------------- stage 5: crop size, limit
	logic [DW:0]   cw, ch;
	logic          v_s5, acc_s5;
	logic [DW-1:0] x1_s5, y1_s5, cw_s5, ch_s5;

	assign cw = {1'b0, x2_s4} - {1'b0, x1_s4};
	assign ch = {1'b0, y2_s4} - {1'b0, y1_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s5 <= !(($signed(cw) < $signed({1'b0, minw})) ||
				($signed(ch) < $signed({1'b0, minh})));
			x1_s5  <= x1_s4;
			y1_s5  <= y1_s4;
			cw_s5  <= cw[DW-1:0];
			ch_s5  <= ch[DW-1:0];
		end
	end

	// ---------------------------------------------------------------- stage 6: aspect product
	logic            v_s6, acc_s6;
	logic [DW-1:0]   x1_s6, y1_s6, cw_s6, ch_s6, den_s6;
	logic [2*DW-1:0] num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6 <= acc_s5;
			x1_s6  <= x1_s5;
			y1_s6  <= y1_s5;
			cw_s6  <= cw_s5;
			ch_s6  <= ch_s5;
			num_s6 <= dh * cw_s5;
			den_s6 <= (ch_s5 == '0) ? DW'(1) : ch_s5;
		end
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------- aspect divider
	logic              div_valid;
	logic [QW-1:0]     div_q;
	logic [SIDE_W-1:0] div_side;
	logic              acc_d;
	logic [DW-1:0]     x1_d, y1_d, cw_d, ch_d;

	plcrop_ceil_div #(
		.MAX_DIM (MAX_DIM),
		.SIDE_W  (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num_s6),
		.den       (den_s6),
		.side_in   ({acc_s6, x1_s6, y1_s6, cw_s6, ch_s6}),
		.out_valid (div_valid),
		.q         (div_q),
		.side_out  (div_side)
	);

	assign {acc_d, x1_d, y1_d, cw_d, ch_d} = div_side;

	// ---------------------------------------------------------------- output register
	logic [QW-1:0] q_even, q_lim, sw;

	assign q_even = {div_q[QW-1:1], 1'b0};
	assign q_lim  = (q_even < {1'b0, dw_sat}) ? q_even : {1'b0, dw_sat};
	assign sw     = (q_lim < QW'(plcrop_pkg::PAD_MIN)) ? QW'(plcrop_pkg::PAD_MIN) : q_lim;

	logic             acc_q;
	logic [OUT_W-1:0] src_x_q, src_y_q, src_width_q, src_height_q, out_width_q, out_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	// A rejected crop reports zeros in every field.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_q        <= acc_d;
			src_x_q      <= acc_d ? OUT_W'(x1_d) : '0;
			src_y_q      <= acc_d ? OUT_W'(y1_d) : '0;
			src_width_q  <= acc_d ? OUT_W'(cw_d) : '0;
			src_height_q <= acc_d ? OUT_W'(ch_d) : '0;
			out_width_q  <= acc_d ? OUT_W'(sw) : '0;
			out_height_q <= acc_d ? OUT_W'(dh) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = acc_q;
	assign m_axis_tdata  = {
		(plcrop_pkg::OUT_TDATA_W - 6 * OUT_W)'(0),
		out_height_q, out_width_q, src_height_q, src_width_q, src_y_q, src_x_q
	};

`ifndef NO_ASSERTIONS
	a_rejected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !acc_q) |-> (m_axis_tdata == '0))
		else $error("rejected crop carries nonzero fields");

	a_width_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && acc_q) |-> (out_width_q >= OUT_W'(plcrop_pkg::PAD_MIN)))
		else $error("accepted crop has output width below the floor");

	a_width_even: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && acc_q) |-> ((out_width_q[0] == 1'b0) ||
			(out_width_q == OUT_W'(dw_sat))))
		else $error("odd output width that is not the destination width");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s6) && $stable(div_valid)))
		else $error("pipeline moved during an output stall");
`endif

endmodule

// File: design/plcrop_ceil_div.sv
`timescale 1ns / 1ps
// Pipelined ceiling divider, one quotient bit per stage, result capped at 2*MAX_DIM.
// Depends on nothing but its parameters; instantiated by plate_crop_region_calculator_top.

module plcrop_ceil_div #(
	parameter int MAX_DIM = 8192,
	parameter int SIDE_W  = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [2*$clog2(MAX_DIM+1)-1:0] num,
	input  logic [$clog2(MAX_DIM+1)-1:0]   den,
	input  logic [SIDE_W-1:0]              side_in,
	output logic                           out_valid,
	output logic [$clog2(MAX_DIM+1):0]     q,
	output logic [SIDE_W-1:0]              side_out
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int QW = DW + 1;
	localparam int NW = 2 * DW + 1;
	localparam logic [QW-1:0] QMAX = QW'(2 * MAX_DIM);

	logic [NW-1:0] numc;
	logic [DW-1:0] hi;

	logic              v_s    [QW+1];
	logic [DW-1:0]     rem_s  [QW+1];
	logic [QW-1:0]     lo_s   [QW+1];
	logic [QW-1:0]     quo_s  [QW+1];
	logic [DW-1:0]     den_s  [QW+1];
	logic              ovf_s  [QW+1];
	logic [SIDE_W-1:0] side_s [QW+1];

	// Ceiling division is floor division of num + den - 1. The upper bits of that
	// sum give the starting remainder; if they already reach den the quotient
	// would not fit in QW bits and is capped anyway.
	assign numc = {1'b0, num} + NW'(den) - NW'(1);
	assign hi   = numc[NW-1:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi;
			lo_s[0]   <= numc[QW-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			ovf_s[0]  <= (hi >= den);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k], lo_s[k][QW-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
				lo_s[k+1]   <= lo_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				den_s[k+1]  <= den_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign q         = (ovf_s[QW] || (quo_s[QW] > QMAX)) ? QMAX : quo_s[QW];
	assign side_out  = side_s[QW];

endmodule

// File: sim/tb_plate_crop_region_calculator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for plate_crop_region_calculator_top: detection boxes in, crop results out.
// Depends on plcrop_pkg and the design; a model inside the bench predicts every result word.

module tb_plate_crop_region_calculator_top;
	import plcrop_pkg::*;

	localparam int FRAC          = FRAC_BITS_DEF;
	localparam int DIM_CAP       = MAX_DIM_DEF;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_BOXES  = 1530;
	localparam int FIX_MIN       = -131072;
	localparam int FIX_MAX       = 131071;

	// Packed so that the struct is the input word itself: left in the lowest bits.
	typedef struct packed {
		logic [IN_W-1:0] bottom;
		logic [IN_W-1:0] right;
		logic [IN_W-1:0] top;
		logic [IN_W-1:0] left;
	} box_t;

	typedef struct packed {
		logic             accepted;
		logic [OUT_W-1:0] out_h;
		logic [OUT_W-1:0] out_w;
		logic [OUT_W-1:0] src_h;
		logic [OUT_W-1:0] src_w;
		logic [OUT_W-1:0] src_y;
		logic [OUT_W-1:0] src_x;
	} crop_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_wr_en;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [REG_W-1:0]       cfg_wdata;

	// Shadow copy of the configuration registers.
	logic [REG_W-1:0] frame_w, frame_h, min_w, min_h, dst_w, dst_h;

	crop_t pending_crops[$];
	int    faults = 0;
	int    cycles = 0;
	int    rx_hold = 0;
	bit    tx_calm = 1'b0;
	bit    rx_calm = 1'b0;

	plate_crop_region_calculator_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int min_i(int a, int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int max_i(int a, int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int even_floor(int v);
		return v - (v & 1);
	endfunction

	function automatic int clip_dim(logic [REG_W-1:0] v);
		return (v > DIM_CAP) ? DIM_CAP : int'(v);
	endfunction

	// Round half up to a whole pixel, then clamp into [0, dim-1].
	function automatic int snap_corner(logic signed [IN_W-1:0] raw, int dim);
		int v;
		int r;
		v = raw;
		v = v + (1 << (FRAC - 1));
		r = (v < 0) ? 0 : (v >>> FRAC);
		return max_i(0, min_i(dim - 1, r));
	endfunction

	function automatic crop_t crop_region_of(box_t b);
		crop_t res;
		int fw, fh, x1, y1, x2, y2, w, h, px, py, cw, ch, dh, sw;
		longint num, den, q;
		fw = clip_dim(frame_w);
		fh = clip_dim(frame_h);
		x1 = even_floor(snap_corner(b.left, fw));
		y1 = even_floor(snap_corner(b.top, fh));
		x2 = min_i(fw, even_floor(snap_corner(b.right, fw) + 1));
		y2 = min_i(fh, even_floor(snap_corner(b.bottom, fh) + 1));
		w = max_i(1, x2 - x1);
		h = max_i(1, y2 - y1);
		px = max_i(PAD_MIN, w / 12);
		py = max_i(PAD_MIN, h / 5);
		x1 = even_floor(max_i(0, x1 - px));
		y1 = even_floor(max_i(0, y1 - py));
		x2 = min_i(fw, even_floor(min_i(fw, x2 + px) + 1));
		y2 = min_i(fh, even_floor(min_i(fh, y2 + py) + 1));
		cw = x2 - x1;
		ch = y2 - y1;
		res = '0;
		// A box still inverted after padding lands here too, since its size is negative.
		if (cw < clip_dim(min_w) || ch < clip_dim(min_h))
			return res;
		dh = clip_dim(dst_h);
		den = max_i(1, ch);
		num = longint'(dh) * cw;
		q = (num + den - 1) / den;
		if (q > 2 * DIM_CAP)
			q = 2 * DIM_CAP;
		sw = max_i(2, min_i(clip_dim(dst_w), even_floor(int'(q))));
		res.accepted = 1'b1;
		res.src_x = x1[OUT_W-1:0];
		res.src_y = y1[OUT_W-1:0];
		res.src_w = cw[OUT_W-1:0];
		res.src_h = ch[OUT_W-1:0];
		res.out_w = sw[OUT_W-1:0];
		res.out_h = dh[OUT_W-1:0];
		return res;
	endfunction

	function automatic box_t mk_box(int l, int t, int r, int b);
		box_t x;
		x.left = l[IN_W-1:0];
		x.top = t[IN_W-1:0];
		x.right = r[IN_W-1:0];
		x.bottom = b[IN_W-1:0];
		return x;
	endfunction

	function automatic int sat_fix(int v);
		return max_i(FIX_MIN, min_i(FIX_MAX, v));
	endfunction

	// Mostly plausible boxes around the frame, some inverted, some pure noise.
	function automatic box_t rand_box();
		int span_x, span_y, l, t, r, b, kind;
		span_x = clip_dim(frame_w) * 16 + 16;
		span_y = clip_dim(frame_h) * 16 + 16;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			return mk_box($urandom(), $urandom(), $urandom(), $urandom());
		l = $urandom_range(0, span_x + 512) - 256;
		t = $urandom_range(0, span_y + 512) - 256;
		r = l + (($urandom_range(0, 3) == 0) ? $urandom_range(0, span_x)
			: $urandom_range(0, span_x / 8 + 64));
		b = t + (($urandom_range(0, 3) == 0) ? $urandom_range(0, span_y)
			: $urandom_range(0, span_y / 8 + 64));
		if (kind == 1)
			return mk_box(sat_fix(r), sat_fix(b), sat_fix(l), sat_fix(t));
		return mk_box(sat_fix(l), sat_fix(t), sat_fix(r), sat_fix(b));
	endfunction

	function automatic int pick_reg(int lo, int hi, int rare);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 16383);
			1: return rare;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	task automatic check_crop();
		crop_t got;
		crop_t want;
		got = {m_axis_tuser, m_axis_tdata[6*OUT_W-1:0]};
		rx_hold = rx_calm ? 0 : $urandom_range(0, 9);
		if (pending_crops.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("unexpected crop word: acc=%0d x=%0d y=%0d w=%0d h=%0d ow=%0d oh=%0d",
					got.accepted, got.src_x, got.src_y, got.src_w, got.src_h,
					got.out_w, got.out_h);
			return;
		end
		want = pending_crops.pop_front();
		if (got.accepted !== want.accepted || got.src_x !== want.src_x ||
				got.src_y !== want.src_y || got.src_w !== want.src_w ||
				got.src_h !== want.src_h || got.out_w !== want.out_w ||
				got.out_h !== want.out_h) begin
			faults++;
			if (faults <= 10) begin
				$display("crop mismatch at %0t", $realtime);
				$display("  want acc=%0d x=%0d y=%0d w=%0d h=%0d ow=%0d oh=%0d",
					want.accepted, want.src_x, want.src_y, want.src_w, want.src_h,
					want.out_w, want.out_h);
				$display("  got  acc=%0d x=%0d y=%0d w=%0d h=%0d ow=%0d oh=%0d",
					got.accepted, got.src_x, got.src_y, got.src_w, got.src_h,
					got.out_w, got.out_h);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_crop();
	end

	// Output side: after each word taken, stall for a drawn number of cycles.
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			m_axis_tready = 1'b0;
			rx_hold = rx_hold - 1;
		end else
			m_axis_tready = 1'b1;
	end

	// Entered and left at a falling edge; valid stays high into the next word when no gap is drawn.
	task automatic send_box(box_t b);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = b;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_crops.push_back(crop_region_of(b));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending_crops.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val[REG_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_FRAME_WIDTH:    frame_w = val[REG_W-1:0];
			REG_FRAME_HEIGHT:   frame_h = val[REG_W-1:0];
			REG_MIN_BOX_WIDTH:  min_w = val[REG_W-1:0];
			REG_MIN_BOX_HEIGHT: min_h = val[REG_W-1:0];
			REG_DEST_WIDTH:     dst_w = val[REG_W-1:0];
			REG_DEST_HEIGHT:    dst_h = val[REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(int fw, int fh, int mw, int mh, int dw, int dh);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
		write_reg(REG_MIN_BOX_WIDTH, mw);
		write_reg(REG_MIN_BOX_HEIGHT, mh);
		write_reg(REG_DEST_WIDTH, dw);
		write_reg(REG_DEST_HEIGHT, dh);
	endtask

	// Register defaults straight out of reset.
	task automatic test_default_regs();
		send_box(mk_box(100*16, 200*16, 260*16, 250*16));
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
		send_box(mk_box(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(300*16, 100*16, 200*16, 150*16));
		send_box(mk_box(500*16, 500*16, 500*16, 500*16));
		// Exact half pixels and values just below them.
		send_box(mk_box(10*16 + 8, 20*16 + 7, 40*16 + 8, 30*16 - 8));
		send_box(mk_box(-8, -9, 20*16, 10*16));
		send_box(mk_box(1900*16, 1070*16, 1920*16 - 1, 1080*16 - 1));
		send_box(mk_box(610*16, 100*16, 640*16, 900*16));
		send_box(mk_box(0, 500*16, 1900*16, 520*16));
	endtask

	// Frames of zero to two pixels and a zero destination height.
	task automatic test_degenerate_frames();
		apply_config(0, 1, 0, 0, 2, 0);
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(16, 16, 48, 48));
		apply_config(1, 0, 0, 0, 160, 48);
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(-8, 8, 8, -8));
		apply_config(2, 2, 2, 2, 2, 1);
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(8, 8, 24, 24));
	endtask

	// Registers above the largest dimension and at it.
	task automatic test_oversized_regs();
		apply_config(16383, 16383, 16383, 16383, 16383, 16383);
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(1000*16, 1000*16, 2000*16, 1500*16));
		apply_config(8192, 8192, 8192, 8192, 8192, 8192);
		send_box(mk_box(FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX));
		send_box(mk_box(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
		apply_config(16383, 16383, 0, 0, 16383, 16383);
		send_box(mk_box(FIX_MIN, 100*16, FIX_MAX, 101*16));
	endtask

	// Reset defaults, then the largest dimensions, then random configurations, each followed by a burst of random boxes.
	task automatic test_random_boxes();
		int sent;
		int phase;
		int n;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_BOXES) begin
			if (phase == 0)
				apply_config(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_MIN_BOX_WIDTH,
					RST_MIN_BOX_HEIGHT, RST_DEST_WIDTH, RST_DEST_HEIGHT);
			else if (phase == 1)
				apply_config(8192, 8192, 0, 0, 8192, 8192);
			else
				apply_config(pick_reg(2, 4096, 8192), pick_reg(2, 4096, 8192),
					pick_reg(0, 40, 8192), pick_reg(0, 40, 8192),
					pick_reg(2, 512, 16383), pick_reg(1, 128, 0));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n = min_i($urandom_range(60, 160), RANDOM_BOXES - sent);
			repeat (n) begin
				send_box(rand_box());
				// Now and then hold the input until the pipeline has drained.
				if ($urandom_range(0, 99) == 0)
					wait_idle();
			end
			sent += n;
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		frame_w = RST_FRAME_WIDTH;
		frame_h = RST_FRAME_HEIGHT;
		min_w = RST_MIN_BOX_WIDTH;
		min_h = RST_MIN_BOX_HEIGHT;
		dst_w = RST_DEST_WIDTH;
		dst_h = RST_DEST_HEIGHT;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_default_regs();
		test_degenerate_frames();
		test_oversized_regs();
		test_random_boxes();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
